// ===== rtl/core/bll_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bll_pkg
// Shared types and constants of the backlight level sequencer: item and
// result layouts, controller register map and the level map coefficients.
// ----------------------------------------------------------------------------
package bll_pkg;

    typedef enum logic [1:0] {
        OP_LED_SET   = 2'd0,
        OP_LEVEL_SET = 2'd1,
        OP_SLEEP     = 2'd2,
        OP_WAKE      = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [7:0]  level_in;
    } item_t;

    typedef struct packed {
        logic [7:0]  reg_addr;
        logic [7:0]  reg_data;
        logic [6:0]  level_now;
        logic        last;
    } result_t;

    // configuration register indexes
    localparam logic CFG_EXP_MODE  = 1'b0;
    localparam logic CFG_MAX_LEVEL = 1'b1;

    localparam logic [7:0] LEVEL_MAX   = 8'd127;

    // controller register map
    localparam logic [7:0] ADDR_BRIGHT = 8'hA0;
    localparam logic [7:0] ADDR_CONFIG = 8'h10;
    localparam logic [7:0] CFG_LINEAR  = 8'h17;
    localparam logic [7:0] CFG_EXPO    = 8'h15;

    // three-piece map: breaks and anchors
    localparam logic [7:0] BREAK_LOW   = 8'd35;
    localparam logic [7:0] BREAK_MID   = 8'd102;
    localparam logic [6:0] ANCHOR_LOW  = 7'h4F;
    localparam logic [6:0] ANCHOR_MID  = 7'h6B;

    // constant divides done as reciprocal multiplies
    // low piece:  v*79/35       -> v * 79*ceil(2^20/35) >> 20
    // mid piece:  (v-35)*28/67  -> (v-35) * 28*ceil(2^20/67) >> 20
    // high piece: d*|mx-107|/153 -> d * (|mx-107|*ceil(2^24/153)) >> 24
    localparam int unsigned LOW_RECIP  = 32'd2366840;
    localparam int unsigned MID_RECIP  = 32'd438228;
    localparam int unsigned HIGH_RECIP = 32'd109656;
    localparam int unsigned LOW_SHIFT  = 20;
    localparam int unsigned HIGH_SHIFT = 24;

    // constant table over max level: scaled slope magnitude of the high piece
    function automatic logic [23:0] high_coef(input logic [6:0] mx);
        logic [6:0] slope;
        slope = (mx < ANCHOR_MID) ? (ANCHOR_MID - mx) : (mx - ANCHOR_MID);
        return 24'(32'(slope) * HIGH_RECIP);
    endfunction

endpackage

// ===== rtl/core/backlight_level_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// backlight_level_sequencer
// Turns backlight events into register writes for a backlight controller.
// ----------------------------------------------------------------------------
// Usage
//   item channel (item_valid / item_stall / item): one backlight event per
//   item: LED level set, direct drive level set, sleep or wake.
//   result channel (result_valid / result_stall / result): controller
//   register writes, zero, one or two per event; last marks the final one.
//   cfg_we / cfg_index / cfg_data: exponential mode and max level, to be
//   written only while no event is in flight; the block does not enforce it.
// Timing
//   an event is mapped while it sits in the input register and its writes
//   enter the queue as it leaves that register; the first write is then
//   offered from the queue; one event per cycle while each gives at most
//   one write and no result stalls; sleep and wake give two writes, one
//   per cycle, so the output port sets the pace.
//   a four-entry result queue takes an event only with room for two writes.
// Reset
//   awake, kept level 0, linear mode, max level 127, queue empty.
// Stall
//   a stalled result holds; item_stall rises with under two queue slots free.
// ----------------------------------------------------------------------------
module backlight_level_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  bll_pkg::item_t  item,
    output logic            result_valid,
    input  logic            result_stall,
    output bll_pkg::result_t result,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [6:0]      cfg_data
);

    localparam int QDEPTH = 4;
    localparam int QPTRW  = $clog2(QDEPTH);
    localparam int QCNTW  = $clog2(QDEPTH + 1);

    logic             exp_reg;
    logic [6:0]       max_reg;
    logic             asleep_reg, asleep_next;
    logic [6:0]       drive_reg, drive_next;

    logic             s1_valid_reg;
    bll_pkg::item_t   s1_item_reg;

    bll_pkg::result_t q_reg [QDEPTH];
    logic [QPTRW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNTW-1:0] count_reg;

    logic             go, accept, pop;
    logic [1:0]       n_push;
    bll_pkg::result_t res0, res1;

    logic [7:0]       lim8;
    logic [14:0]      lin_prod;
    logic [16:0]      lin_sum;
    logic [31:0]      low_prod, mid_prod, high_prod;
    logic [7:0]       mid_d, high_d;
    logic [6:0]       lin_lvl, low_lvl, mid_lvl, high_q, high_lvl, map_lvl;
    logic [6:0]       set_lvl;
    logic [7:0]       set_src;

    // handshakes
    assign go         = s1_valid_reg && (count_reg <= QCNTW'(QDEPTH - 2));
    assign item_stall = s1_valid_reg && !go;
    assign accept     = item_valid && !item_stall;
    assign result_valid = (count_reg != '0);
    assign result       = q_reg[rd_ptr_reg];
    assign pop          = result_valid && !result_stall;

    // level map
    assign lim8 = ({1'b0, max_reg} > bll_pkg::LEVEL_MAX) ? bll_pkg::LEVEL_MAX
                                                         : {1'b0, max_reg};

    assign lin_prod = 15'(s1_item_reg.level_in) * 15'(max_reg);
    assign lin_sum  = 17'(lin_prod) + 17'(lin_prod >> 8) + 17'd1;
    assign lin_lvl  = lin_sum[14:8];

    assign low_prod = 32'(s1_item_reg.level_in) * bll_pkg::LOW_RECIP;
    assign low_lvl  = 7'(low_prod >> bll_pkg::LOW_SHIFT);

    assign mid_d    = s1_item_reg.level_in - bll_pkg::BREAK_LOW;
    assign mid_prod = 32'(mid_d) * bll_pkg::MID_RECIP;
    assign mid_lvl  = 7'(mid_prod >> bll_pkg::LOW_SHIFT) + bll_pkg::ANCHOR_LOW;

    assign high_d    = s1_item_reg.level_in - bll_pkg::BREAK_MID;
    assign high_prod = 32'(high_d) * 32'(bll_pkg::high_coef(max_reg));
    assign high_q    = 7'(high_prod >> bll_pkg::HIGH_SHIFT);
    assign high_lvl  = (max_reg < bll_pkg::ANCHOR_MID) ? (bll_pkg::ANCHOR_MID - high_q)
                                                       : (bll_pkg::ANCHOR_MID + high_q);

    always_comb
    begin
        if (!exp_reg)
        begin
            map_lvl = lin_lvl;
        end
        else if (s1_item_reg.level_in <= bll_pkg::BREAK_LOW)
        begin
            map_lvl = low_lvl;
        end
        else if (s1_item_reg.level_in <= bll_pkg::BREAK_MID)
        begin
            map_lvl = mid_lvl;
        end
        else
        begin
            map_lvl = high_lvl;
        end
    end

    // clamp to the limit
    assign set_src = (s1_item_reg.opcode == bll_pkg::OP_LED_SET) ? {1'b0, map_lvl}
                                                                 : s1_item_reg.level_in;
    assign set_lvl = (set_src > lim8) ? lim8[6:0] : set_src[6:0];

    // event decode
    always_comb
    begin
        asleep_next = asleep_reg;
        drive_next  = drive_reg;
        n_push      = 2'd0;
        res0        = '0;
        res1        = '0;
        unique case (s1_item_reg.opcode) inside
            bll_pkg::OP_LED_SET, bll_pkg::OP_LEVEL_SET:
            begin
                if (!(s1_item_reg.opcode == bll_pkg::OP_LED_SET && map_lvl == drive_reg))
                begin
                    drive_next = set_lvl;
                    if (!asleep_reg && drive_reg != set_lvl)
                    begin
                        n_push = 2'd1;
                        res0   = '{reg_addr: bll_pkg::ADDR_BRIGHT, reg_data: {1'b0, set_lvl},
                                   level_now: set_lvl, last: 1'b1};
                    end
                end
            end
            bll_pkg::OP_SLEEP:
            begin
                if (!asleep_reg)
                begin
                    asleep_next = 1'b1;
                    n_push      = 2'd2;
                    res0 = '{reg_addr: bll_pkg::ADDR_BRIGHT, reg_data: 8'd0,
                             level_now: drive_reg, last: 1'b0};
                    res1 = '{reg_addr: bll_pkg::ADDR_CONFIG, reg_data: 8'd0,
                             level_now: drive_reg, last: 1'b1};
                end
            end
            bll_pkg::OP_WAKE:
            begin
                if (asleep_reg)
                begin
                    asleep_next = 1'b0;
                    n_push      = 2'd2;
                    res0 = '{reg_addr: bll_pkg::ADDR_CONFIG,
                             reg_data: exp_reg ? bll_pkg::CFG_EXPO : bll_pkg::CFG_LINEAR,
                             level_now: drive_reg, last: 1'b0};
                    res1 = '{reg_addr: bll_pkg::ADDR_BRIGHT, reg_data: {1'b0, drive_reg},
                             level_now: drive_reg, last: 1'b1};
                end
            end
            default:
            begin
                n_push = 2'd0;
            end
        endcase
    end

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg      <= 1'b0;
            max_reg      <= bll_pkg::LEVEL_MAX[6:0];
            asleep_reg   <= 1'b0;
            drive_reg    <= '0;
            s1_valid_reg <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == bll_pkg::CFG_EXP_MODE)
                begin
                    exp_reg <= cfg_data[0];
                end
                else
                begin
                    max_reg <= cfg_data;
                end
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (go)
            begin
                asleep_reg <= asleep_next;
                drive_reg  <= drive_next;
                wr_ptr_reg <= wr_ptr_reg + QPTRW'(n_push);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTRW'(1);
            end
            count_reg <= count_reg + (go ? QCNTW'(n_push) : QCNTW'(0)) - QCNTW'(pop);
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item;
        end
        if (go && n_push != 2'd0)
        begin
            q_reg[wr_ptr_reg] <= res0;
        end
        if (go && n_push == 2'd2)
        begin
            q_reg[wr_ptr_reg + QPTRW'(1)] <= res1;
        end
    end

endmodule

// ===== rtl/core/bll_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bll_checker
// Port-level checks on the result channel of the backlight level sequencer.
// ----------------------------------------------------------------------------
module bll_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             result_valid,
    input  logic             result_stall,
    input  bll_pkg::result_t result
);

    // a stalled result stays offered
    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result withdrawn while stalled");

    // a stalled result keeps its payload
    a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result payload changed while stalled");

    // the second write of a pair is already queued behind the first
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !result.last |=> result_valid)
        else $error("second write of a pair missing");

    // a first write of a pair is either blanking or the config word
    a_first_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |->
            (result.reg_addr == bll_pkg::ADDR_BRIGHT && result.reg_data == 8'd0) ||
            (result.reg_addr == bll_pkg::ADDR_CONFIG))
        else $error("unexpected first write of a pair");

    // a closing brightness write carries the kept level
    a_bright_level: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last && result.reg_addr == bll_pkg::ADDR_BRIGHT |->
            result.reg_data == {1'b0, result.level_now})
        else $error("brightness write differs from kept level");

endmodule

bind backlight_level_sequencer bll_checker u_bll_checker (.*);

// ===== tb/sv/bll_write_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bll_write_checker
// Watches the event and register-write channels of the backlight level
// sequencer. Keeps its own copy of the mode, the level limit, the sleep
// flag and the kept drive level. Predicts the controller writes for every
// accepted event and compares each accepted write, field by field, with
// the oldest predicted one.
// ----------------------------------------------------------------------------
module bll_write_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_stall,
    input  bll_pkg::item_t    item,
    input  logic              result_valid,
    input  logic              result_stall,
    input  bll_pkg::result_t  result,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [6:0]        cfg_data,
    output int                fail_count,
    output int                pending
);

    localparam int LED_SPAN = 255;
    localparam int BRK_LO   = int'(bll_pkg::BREAK_LOW);
    localparam int BRK_MID  = int'(bll_pkg::BREAK_MID);
    localparam int ANC_LO   = int'(bll_pkg::ANCHOR_LOW);
    localparam int ANC_MID  = int'(bll_pkg::ANCHOR_MID);
    localparam int LVL_CAP  = int'(bll_pkg::LEVEL_MAX);

    logic               exp_mode;
    logic [6:0]         max_lvl;
    logic               asleep;
    logic [6:0]         drive;
    bll_pkg::result_t   expected_writes[$];

    task automatic report(input string msg);
        fail_count++;
        $display("ERROR %0t: %s", $time, msg);
    endtask

    // led level to drive level, signed and truncating toward zero
    function automatic int map_led(input int v);
        int mx;
        mx = int'(max_lvl);
        if (!exp_mode)
            return v * mx / LED_SPAN;
        if (v <= BRK_LO)
            return v * ANC_LO / BRK_LO;
        if (v <= BRK_MID)
            return (v - BRK_LO) * (ANC_MID - ANC_LO) / (BRK_MID - BRK_LO) + ANC_LO;
        return (v - BRK_MID) * (mx - ANC_MID) / (LED_SPAN - BRK_MID) + ANC_MID;
    endfunction

    function automatic bll_pkg::result_t make_write(input logic [7:0] addr,
                                                    input logic [7:0] data,
                                                    input logic fin);
        bll_pkg::result_t w;
        w.reg_addr  = addr;
        w.reg_data  = data;
        w.level_now = drive;
        w.last      = fin;
        return w;
    endfunction

    task automatic apply_level(input int next);
        int lim;
        lim = int'(max_lvl);
        if (lim > LVL_CAP)
            lim = LVL_CAP;
        if (next > lim)
            next = lim;
        if (next < 0)
            next = 0;
        if (!asleep && int'(drive) != next)
        begin
            drive = 7'(next);
            expected_writes.push_back(make_write(bll_pkg::ADDR_BRIGHT, 8'(next), 1'b1));
        end
        drive = 7'(next);
    endtask

    task automatic predict_writes(input bll_pkg::item_t ev);
        int next;
        case (ev.opcode)
            bll_pkg::OP_LED_SET:
            begin
                // unclamped map equal to kept level: nothing at all
                next = map_led(int'(ev.level_in));
                if (int'(drive) != next)
                    apply_level(next);
            end
            bll_pkg::OP_LEVEL_SET:
                apply_level(int'(ev.level_in));
            bll_pkg::OP_SLEEP:
                if (!asleep)
                begin
                    asleep = 1'b1;
                    expected_writes.push_back(make_write(bll_pkg::ADDR_BRIGHT, 8'd0, 1'b0));
                    expected_writes.push_back(make_write(bll_pkg::ADDR_CONFIG, 8'd0, 1'b1));
                end
            default:
                if (asleep)
                begin
                    asleep = 1'b0;
                    expected_writes.push_back(make_write(bll_pkg::ADDR_CONFIG,
                                              exp_mode ? bll_pkg::CFG_EXPO
                                                       : bll_pkg::CFG_LINEAR, 1'b0));
                    expected_writes.push_back(make_write(bll_pkg::ADDR_BRIGHT,
                                                         {1'b0, drive}, 1'b1));
                end
        endcase
    endtask

    task automatic check_write(input bll_pkg::result_t got);
        bll_pkg::result_t want;
        if (expected_writes.size() == 0)
            report($sformatf("write with none expected: addr %h data %h",
                             got.reg_addr, got.reg_data));
        else
        begin
            want = expected_writes.pop_front();
            if (got.reg_addr !== want.reg_addr)
                report($sformatf("reg_addr %h, expected %h", got.reg_addr, want.reg_addr));
            if (got.reg_data !== want.reg_data)
                report($sformatf("reg_data %h, expected %h", got.reg_data, want.reg_data));
            if (got.level_now !== want.level_now)
                report($sformatf("level_now %0d, expected %0d", got.level_now, want.level_now));
            if (got.last !== want.last)
                report($sformatf("last %b, expected %b", got.last, want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_mode   = 1'b0;
            max_lvl    = 7'(bll_pkg::LEVEL_MAX);
            asleep     = 1'b0;
            drive      = 7'd0;
            expected_writes.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
                check_write(result);
            if (cfg_we)
            begin
                case (cfg_index)
                    bll_pkg::CFG_EXP_MODE:  exp_mode = cfg_data[0];
                    bll_pkg::CFG_MAX_LEVEL: max_lvl  = cfg_data;
                endcase
            end
            if (item_valid && !item_stall)
                predict_writes(item);
            pending = expected_writes.size();
        end
    end

endmodule

// ===== tb/sv/tb_backlight_level_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_backlight_level_sequencer
// Drives backlight events into the sequencer in random bursts while the
// write side stalls on a pattern of its own, changes mode and max level
// between idle phases, and leaves prediction and comparison to the
// checker beside the block. Gives the verdict at the end of the run.
// ----------------------------------------------------------------------------
module tb_backlight_level_sequencer;

    localparam int PHASE_ITEMS    = 165;
    localparam int SETTLE_CYCLES  = 12;
    localparam int LONG_HOLD      = 60;
    localparam int WATCHDOG_LIMIT = 2000;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    bll_pkg::item_t     item;
    logic               result_valid;
    logic               result_stall;
    bll_pkg::result_t   result;
    logic               cfg_we;
    logic               cfg_index;
    logic [6:0]         cfg_data;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles;
    bit                 hold_req;

    backlight_level_sequencer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    bll_write_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic push_item(input bll_pkg::item_t ev);
        item       <= ev;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        @(negedge clk);
    endtask

    task automatic send(input bll_pkg::opcode_t op, input logic [7:0] lvl);
        bll_pkg::item_t ev;
        ev.opcode   = op;
        ev.level_in = lvl;
        push_item(ev);
    endtask

    function automatic bll_pkg::item_t random_event();
        bll_pkg::item_t ev;
        int             pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            ev.opcode = bll_pkg::OP_LED_SET;
        else if (pick < 75)
            ev.opcode = bll_pkg::OP_LEVEL_SET;
        else if (pick < 87)
            ev.opcode = bll_pkg::OP_SLEEP;
        else
            ev.opcode = bll_pkg::OP_WAKE;
        if ($urandom_range(0, 4) == 0)
        begin
            case ($urandom_range(0, 9))
                0:       ev.level_in = 8'd0;
                1:       ev.level_in = 8'd255;
                2:       ev.level_in = 8'd1;
                3:       ev.level_in = 8'd35;
                4:       ev.level_in = 8'd36;
                5:       ev.level_in = 8'd102;
                6:       ev.level_in = 8'd103;
                7:       ev.level_in = 8'd127;
                8:       ev.level_in = 8'd128;
                default: ev.level_in = 8'd254;
            endcase
        end
        else
            ev.level_in = 8'($urandom);
        return ev;
    endfunction

    task automatic set_config(input logic mode, input logic [6:0] lvl);
        cfg_we    <= 1'b1;
        cfg_index <= bll_pkg::CFG_EXP_MODE;
        cfg_data  <= {6'd0, mode};
        @(negedge clk);
        cfg_index <= bll_pkg::CFG_MAX_LEVEL;
        cfg_data  <= lvl;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // sender stops and waits for every write, then for the block to empty
    task automatic settle();
        item_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(input logic mode, input logic [6:0] lvl, input logic dense);
        int   burst;
        int   gap;
        logic drain;
        set_config(mode, lvl);
        burst = 0;
        if (dense)
            hold_req = 1'b1;
        repeat (PHASE_ITEMS)
        begin
            if (burst == 0)
            begin
                gap   = dense ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(1, 12)
                                                              : $urandom_range(0, 2));
                drain = !dense && ($urandom_range(0, 39) == 0);
                if (gap > 0 || drain)
                begin
                    item_valid <= 1'b0;
                    while (drain && pending != 0)
                        @(negedge clk);
                    repeat (gap > 0 ? gap : 1) @(negedge clk);
                end
                burst = $urandom_range(1, 24);
            end
            push_item(random_event());
            burst--;
        end
        settle();
    endtask

    // write side: random stall pattern, plus one long hold on request
    initial
    begin : receiver
        int run;
        int mode;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
            end
            mode = $urandom_range(0, 3);
            run  = $urandom_range(1, 40);
            repeat (run)
            begin
                case (mode)
                    0:       result_stall <= 1'b0;
                    1:       result_stall <= ($urandom_range(0, 3) == 0);
                    2:       result_stall <= 1'($urandom_range(0, 1));
                    default: result_stall <= ($urandom_range(0, 3) != 0);
                endcase
                @(negedge clk);
            end
        end
    end

    initial
    begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        item_valid = 1'b0;
        item       = '0;
        cfg_we     = 1'b0;
        cfg_index  = bll_pkg::CFG_EXP_MODE;
        cfg_data   = '0;
        rst_n      = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // breaks of the three-piece map, clamps, sleep and wake corners
        set_config(1'b1, 7'd127);
        send(bll_pkg::OP_LED_SET, 8'd0);
        send(bll_pkg::OP_LED_SET, 8'd255);
        send(bll_pkg::OP_LED_SET, 8'd35);
        send(bll_pkg::OP_LED_SET, 8'd36);
        send(bll_pkg::OP_LED_SET, 8'd102);
        send(bll_pkg::OP_LED_SET, 8'd103);
        send(bll_pkg::OP_LED_SET, 8'd1);
        send(bll_pkg::OP_LEVEL_SET, 8'd255);
        send(bll_pkg::OP_LEVEL_SET, 8'd128);
        send(bll_pkg::OP_LEVEL_SET, 8'd0);
        send(bll_pkg::OP_LEVEL_SET, 8'd127);
        send(bll_pkg::OP_SLEEP, 8'h00);
        send(bll_pkg::OP_SLEEP, 8'hFF);
        send(bll_pkg::OP_LED_SET, 8'd200);
        send(bll_pkg::OP_LEVEL_SET, 8'd5);
        send(bll_pkg::OP_WAKE, 8'h00);
        send(bll_pkg::OP_WAKE, 8'hFF);
        send(bll_pkg::OP_LEVEL_SET, 8'h55);
        send(bll_pkg::OP_LEVEL_SET, 8'hAA);
        send(bll_pkg::OP_LED_SET, 8'hAA);
        send(bll_pkg::OP_LED_SET, 8'h55);
        send(bll_pkg::OP_LED_SET, 8'h55);
        settle();

        run_phase(1'b0, 7'd127, 1'b1);
        run_phase(1'b1, 7'd1, 1'b0);
        run_phase(1'b0, 7'd0, 1'b0);
        run_phase(1'b1, 7'd107, 1'b0);
        run_phase(1'b0, 7'd1, 1'b0);
        run_phase(1'b1, 7'd0, 1'b0);
        run_phase(1'b1, 7'd127, 1'b1);
        run_phase(1'b0, 7'd64, 1'b0);
        run_phase(1'b1, 7'($urandom_range(1, 127)), 1'b0);
        run_phase(1'b0, 7'($urandom_range(1, 127)), 1'b0);

        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
